@@ hdl/aald_pkg.sv @@
package aald_pkg;

  // Field and state widths.
  localparam int unsigned SampleBits = 16;
  localparam int unsigned LenBits    = 13;
  localparam int unsigned InvBits    = 25;
  localparam int unsigned PosBits    = 25;
  localparam int unsigned SumBits    = 28;
  localparam int unsigned IdxBits    = 12;
  localparam int unsigned FracBits   = 24;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 25;

  // Longest line the block handles.
  localparam logic [LenBits-1:0] MaxLine = LenBits'(4096);

  // Queue between front and back.
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = 2;
  localparam int unsigned QueueCntBits = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegSourceLength  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegDestLength    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegInverseLength = 2'd2;

  // Reset values of the registers.
  localparam logic [LenBits-1:0] ResetSourceLength = LenBits'(1);
  localparam logic [LenBits-1:0] ResetDestLength   = LenBits'(1);
  localparam logic [InvBits-1:0] ResetInverse      = InvBits'(1) << FracBits;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic [LenBits-1:0]    first_part;
    logic [LenBits-1:0]    rest;
    logic                  close;
    logic                  last;
  } aald_item_t;

  // Settings and line restart as seen by the back.
  typedef struct packed {
    logic               restart;
    logic [InvBits-1:0] inverse;
  } aald_ctrl_t;

  // Source length as used: zero counts as one, long lines are clamped.
  function automatic logic [LenBits-1:0] eff_src(input logic [LenBits-1:0] len);
    logic [LenBits-1:0] s;
    s = len;
    if (s == '0) s = LenBits'(1);
    if (s > MaxLine) s = MaxLine;
    return s;
  endfunction

  // Destination length as used: at least one and at most the source length.
  function automatic logic [LenBits-1:0] eff_dst(input logic [LenBits-1:0] len,
                                                 input logic [LenBits-1:0] src);
    logic [LenBits-1:0] d;
    d = len;
    if (d == '0) d = LenBits'(1);
    if (d > src) d = src;
    return d;
  endfunction

endpackage

@@ hdl/aald_front.sv @@
module aald_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aald_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [aald_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic                                accept_i,
  input  logic [aald_pkg::SampleBits-1:0]     sample_i,
  output aald_pkg::aald_item_t                item_o,
  output aald_pkg::aald_ctrl_t                ctrl_o
);

  logic [aald_pkg::LenBits-1:0] src_len_q, src_len_d;
  logic [aald_pkg::LenBits-1:0] dst_len_q, dst_len_d;
  logic [aald_pkg::InvBits-1:0] inv_q, inv_d;

  logic [aald_pkg::IdxBits-1:0] source_index_q;
  logic [aald_pkg::PosBits-1:0] scaled_position_q;
  logic [aald_pkg::PosBits-1:0] dest_boundary_q;

  logic [aald_pkg::LenBits-1:0] s_eff, d_eff, s_new;
  logic [aald_pkg::PosBits-1:0] end_pos;
  logic                         last;
  logic                         close;

  // Register writes; an index past the list leaves every register alone.
  always_comb begin
    src_len_d = src_len_q;
    dst_len_d = dst_len_q;
    inv_d     = inv_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        aald_pkg::RegSourceLength:  src_len_d = cfg_data_i[aald_pkg::LenBits-1:0];
        aald_pkg::RegDestLength:    dst_len_d = cfg_data_i[aald_pkg::LenBits-1:0];
        aald_pkg::RegInverseLength: inv_d     = cfg_data_i[aald_pkg::InvBits-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming sample against the open destination interval.
  always_comb begin
    s_eff   = aald_pkg::eff_src(src_len_q);
    d_eff   = aald_pkg::eff_dst(dst_len_q, s_eff);
    s_new   = aald_pkg::eff_src(src_len_d);
    end_pos = scaled_position_q + aald_pkg::PosBits'(d_eff);
    last    = (aald_pkg::LenBits'(source_index_q) + aald_pkg::LenBits'(1)) >= s_eff;
    close   = (end_pos >= dest_boundary_q) || last;

    item_o.sample = sample_i;
    item_o.close  = close;
    item_o.last   = last;
    if (end_pos >= dest_boundary_q) begin
      item_o.first_part = aald_pkg::LenBits'(dest_boundary_q - scaled_position_q);
    end else begin
      item_o.first_part = d_eff;
    end
    if (end_pos > dest_boundary_q) begin
      item_o.rest = aald_pkg::LenBits'(end_pos - dest_boundary_q);
    end else begin
      item_o.rest = '0;
    end
  end

  assign ctrl_o.restart = cfg_we_i;
  assign ctrl_o.inverse = inv_q;

  // Settings and line position; any write restarts the line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q         <= aald_pkg::ResetSourceLength;
      dst_len_q         <= aald_pkg::ResetDestLength;
      inv_q             <= aald_pkg::ResetInverse;
      source_index_q    <= '0;
      scaled_position_q <= '0;
      dest_boundary_q   <= aald_pkg::PosBits'(aald_pkg::ResetSourceLength);
    end else if (cfg_we_i) begin
      src_len_q         <= src_len_d;
      dst_len_q         <= dst_len_d;
      inv_q             <= inv_d;
      source_index_q    <= '0;
      scaled_position_q <= '0;
      dest_boundary_q   <= aald_pkg::PosBits'(s_new);
    end else if (accept_i) begin
      if (last) begin
        source_index_q    <= '0;
        scaled_position_q <= '0;
        dest_boundary_q   <= aald_pkg::PosBits'(s_eff);
      end else begin
        source_index_q    <= source_index_q + aald_pkg::IdxBits'(1);
        scaled_position_q <= end_pos;
        if (close) begin
          dest_boundary_q <= dest_boundary_q + aald_pkg::PosBits'(s_eff);
        end
      end
    end
  end

  // The open interval always ends past the next sample start.
  a_boundary_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dest_boundary_q > scaled_position_q)
    else $error("destination boundary fell behind the sample position");

  // A sample always lands some of its weight in the open pixel.
  a_first_part_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (item_o.first_part != '0))
    else $error("accepted sample with zero overlap");

endmodule

@@ hdl/aald_queue.sv @@
module aald_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  aald_pkg::aald_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output aald_pkg::aald_item_t item_o,
  output logic                 empty_o
);

  aald_pkg::aald_item_t                 slot_q [aald_pkg::QueueDepth];
  logic [aald_pkg::QueuePtrBits-1:0]    wr_ptr_q;
  logic [aald_pkg::QueuePtrBits-1:0]    rd_ptr_q;
  logic [aald_pkg::QueueCntBits-1:0]    count_q;
  logic                                 do_push, do_pop;

  assign full_o  = count_q == aald_pkg::QueueCntBits'(aald_pkg::QueueDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + aald_pkg::QueuePtrBits'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + aald_pkg::QueuePtrBits'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + aald_pkg::QueueCntBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - aald_pkg::QueueCntBits'(1);
      end
    end
  end

  // The fill count matches the pointer distance.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[aald_pkg::QueuePtrBits-1:0])
    else $error("queue count disagrees with pointers");

endmodule

@@ hdl/aald_back.sv @@
module aald_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aald_pkg::aald_ctrl_t            ctrl_i,
  input  aald_pkg::aald_item_t            item_i,
  input  logic                            item_empty_i,
  output logic                            item_pop_o,
  input  logic                            pop_i,
  output logic                            empty_o,
  output logic [aald_pkg::SampleBits-1:0] value_o,
  output logic                            line_done_o
);

  localparam int unsigned NormBits = aald_pkg::SumBits + aald_pkg::InvBits;
  localparam int unsigned ProdBits = aald_pkg::SumBits;

  localparam logic [2:0] BIdle = 3'd0;
  localparam logic [2:0] BMul  = 3'd1;
  localparam logic [2:0] BAcc  = 3'd2;
  localparam logic [2:0] BNorm = 3'd3;
  localparam logic [2:0] BOut  = 3'd4;

  logic [2:0]                      state_q, state_d;
  aald_pkg::aald_item_t            item_q;
  logic [ProdBits-1:0]             prod_first_q, prod_rest_q;
  logic [aald_pkg::SumBits-1:0]    weighted_sum_q, acc_q, sum;
  logic [NormBits-1:0]             norm_q;
  logic [NormBits-aald_pkg::FracBits-1:0] scaled;
  logic [aald_pkg::SampleBits-1:0] sat_value;
  logic                            out_valid_q;
  logic [aald_pkg::SampleBits-1:0] out_value_q;
  logic                            out_done_q;
  logic                            out_free;

  assign item_pop_o = (state_q == BIdle) && !item_empty_i;
  assign out_free   = !out_valid_q || pop_i;
  assign empty_o    = !out_valid_q;
  assign value_o    = out_value_q;
  assign line_done_o = out_done_q;

  // Sum of the open pixel including this sample's share.
  assign sum = weighted_sum_q + prod_first_q;

  // Drop the fraction and clamp to the largest sample.
  always_comb begin
    scaled = norm_q[NormBits-1:aald_pkg::FracBits];
    if (|scaled[NormBits-aald_pkg::FracBits-1:aald_pkg::SampleBits]) begin
      sat_value = '1;
    end else begin
      sat_value = scaled[aald_pkg::SampleBits-1:0];
    end
  end

  // Sequencer: fetch, multiply, accumulate, and for a closing sample normalize and hand over.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BIdle: if (!item_empty_i) state_d = BMul;
      BMul:  state_d = BAcc;
      BAcc:  state_d = item_q.close ? BNorm : BIdle;
      BNorm: state_d = BOut;
      BOut:  if (out_free) state_d = BIdle;
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (item_pop_o) item_q <= item_i;
    if (state_q == BMul) begin
      prod_first_q <= ProdBits'(item_q.first_part) * ProdBits'(item_q.sample);
      prod_rest_q  <= ProdBits'(item_q.rest) * ProdBits'(item_q.sample);
    end
    if (state_q == BAcc) acc_q <= sum;
    if (state_q == BNorm) norm_q <= NormBits'(acc_q) * NormBits'(ctrl_i.inverse);
    if (state_q == BOut && out_free) begin
      out_value_q <= sat_value;
      out_done_q  <= item_q.last;
    end
  end

  // Running sum of the open pixel; cleared when the line restarts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weighted_sum_q <= '0;
    end else if (ctrl_i.restart) begin
      weighted_sum_q <= '0;
    end else if (state_q == BAcc) begin
      weighted_sum_q <= item_q.close ? prod_rest_q : sum;
    end
  end

  // Output register holds one result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == BOut && out_free) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Only a closing sample goes through normalization.
  a_norm_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BNorm || state_q == BOut) |-> item_q.close)
    else $error("normalizing a sample that closes no pixel");

endmodule

@@ hdl/area_average_line_downscaler.sv @@
// Area-averaging line downscaler. Source samples of one line are pushed in
// order; each destination pixel is the overlap-weighted sum of the samples
// it covers, times inverse_source_length, shifted down by 24 and clamped to
// the sample range, and comes out once its interval closes, with line_done
// set on the last pixel of the line. The front takes one sample per cycle
// into a four-entry queue while there is room; the back's multiply,
// accumulate and normalize sequencer handles one sample at a time: fetch,
// multiply and accumulate, then normalize and a hand-over that waits for a
// free output on a closing sample. Write the configuration only while
// the block is idle; every write, to any index, restarts the line.
module area_average_line_downscaler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aald_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [aald_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [aald_pkg::SampleBits-1:0]     sample_i,
  input  logic                                pop,
  output logic                                empty,
  output logic [aald_pkg::SampleBits-1:0]     value_o,
  output logic                                line_done_o
);

  aald_pkg::aald_item_t front_item, back_item;
  aald_pkg::aald_ctrl_t ctrl;
  logic                 accept;
  logic                 queue_empty;
  logic                 queue_pop;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = push && !full;

  aald_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .sample_i    (sample_i),
    .item_o      (front_item),
    .ctrl_o      (ctrl)
  );

  aald_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (queue_pop),
    .item_o  (back_item),
    .empty_o (queue_empty)
  );

  aald_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .item_i       (back_item),
    .item_empty_i (queue_empty),
    .item_pop_o   (queue_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .value_o      (value_o),
    .line_done_o  (line_done_o)
  );

endmodule

@@ test/area_average_line_downscaler_tb.sv @@
module area_average_line_downscaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the end of the register list; a write there only restarts the line.
  localparam logic [aald_pkg::CfgIdxBits-1:0] RegNoneIdx = 2'd3;

  localparam int RandomItems  = 800;
  localparam int FinalSamples = 64;
  localparam int DrainCycles  = 40;
  localparam int HoldCycles   = 300;
  localparam int PrintCap     = 40;

  typedef struct packed {
    logic [aald_pkg::SampleBits-1:0] value;
    logic                            line_done;
  } pixel_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [aald_pkg::CfgIdxBits-1:0] reg_idx;
    logic [aald_pkg::CfgBits-1:0]    reg_data;
    logic [aald_pkg::SampleBits-1:0] sample;
    bit                              typed;
    pixel_t                          want;
  } plan_row_t;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_ONE_IN_FOUR, POP_RARE_STALL} pop_style_e;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [aald_pkg::CfgIdxBits-1:0] cfg_index_i;
  logic [aald_pkg::CfgBits-1:0]    cfg_data_i;
  logic                            push;
  logic                            full;
  logic [aald_pkg::SampleBits-1:0] sample_i;
  logic                            pop;
  logic                            empty;
  logic [aald_pkg::SampleBits-1:0] value_o;
  logic                            line_done_o;

  area_average_line_downscaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .pop         (pop),
    .empty       (empty),
    .value_o     (value_o),
    .line_done_o (line_done_o)
  );

  // Shadow copy of the settings and of the line position.
  logic [aald_pkg::LenBits-1:0]  src_len_reg;
  logic [aald_pkg::LenBits-1:0]  dst_len_reg;
  logic [aald_pkg::InvBits-1:0]  inv_reg;
  logic [aald_pkg::IdxBits-1:0]  line_idx;
  logic [aald_pkg::PosBits-1:0]  pos_units;
  logic [aald_pkg::PosBits-1:0]  boundary_units;
  logic [aald_pkg::SumBits-1:0]  area_sum;

  pixel_t    pixels_due[$];
  plan_row_t plan[$];

  int  mismatches;
  int  samples_sent;
  int  pixels_seen;
  int  settings_used;
  int  burst_left;
  bit  hold_req;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Line length as the block uses it: zero counts as one, long lines clamp.
  function automatic logic [aald_pkg::LenBits-1:0] used_src_len();
    logic [aald_pkg::LenBits-1:0] s;
    s = src_len_reg;
    if (s == '0) s = aald_pkg::LenBits'(1);
    if (s > aald_pkg::LenBits'(4096)) s = aald_pkg::LenBits'(4096);
    return s;
  endfunction

  // Destination length: at least one, never more than the source length.
  function automatic logic [aald_pkg::LenBits-1:0] used_dst_len();
    logic [aald_pkg::LenBits-1:0] d;
    logic [aald_pkg::LenBits-1:0] s;
    s = used_src_len();
    d = dst_len_reg;
    if (d == '0) d = aald_pkg::LenBits'(1);
    if (d > s) d = s;
    return d;
  endfunction

  function automatic void start_new_line();
    line_idx       = '0;
    pos_units      = '0;
    boundary_units = aald_pkg::PosBits'(used_src_len());
    area_sum       = '0;
  endfunction

  // Splits one sample over the open pixel and the next one, and closes the
  // open pixel when the sample reaches its boundary or ends the line.
  task automatic accumulate_sample(input logic [aald_pkg::SampleBits-1:0] x, output bit got,
                                   output pixel_t px);
    logic [aald_pkg::LenBits-1:0] s;
    logic [aald_pkg::LenBits-1:0] d;
    logic [aald_pkg::PosBits-1:0] start_u;
    logic [aald_pkg::PosBits-1:0] end_u;
    logic [aald_pkg::PosBits-1:0] first_part;
    logic [aald_pkg::PosBits-1:0] rest;
    logic                         last;
    logic [63:0]                  scaled;
    s       = used_src_len();
    d       = used_dst_len();
    start_u = pos_units;
    end_u   = start_u + aald_pkg::PosBits'(d);
    last    = ({1'b0, line_idx} + 13'd1) >= s;
    got     = 1'b0;
    px      = '0;
    if (end_u < boundary_units && !last) begin
      area_sum = area_sum + aald_pkg::SumBits'(d) * aald_pkg::SumBits'(x);
    end else begin
      first_part = (end_u >= boundary_units) ? boundary_units - start_u
                                             : aald_pkg::PosBits'(d);
      rest       = (end_u > boundary_units) ? end_u - boundary_units : '0;
      area_sum   = area_sum + aald_pkg::SumBits'(first_part) * aald_pkg::SumBits'(x);
      scaled     = (64'(area_sum) * 64'(inv_reg)) >> aald_pkg::FracBits;
      px.value     = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[aald_pkg::SampleBits-1:0];
      px.line_done = last;
      got          = 1'b1;
      area_sum       = aald_pkg::SumBits'(rest) * aald_pkg::SumBits'(x);
      boundary_units = boundary_units + aald_pkg::PosBits'(s);
    end
    if (last) begin
      start_new_line();
    end else begin
      line_idx  = line_idx + aald_pkg::IdxBits'(1);
      pos_units = end_u;
    end
  endtask

  // Offers one sample in bursts with random gaps; called and left at a falling edge.
  task automatic push_sample(input logic [aald_pkg::SampleBits-1:0] s, input bit typed,
                             input pixel_t want);
    bit     got;
    pixel_t px;
    if (burst_left <= 0) begin
      push = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    push     = 1'b1;
    sample_i = s;
    do @(posedge clk_i); while (full !== 1'b0);
    accumulate_sample(s, got, px);
    if (got) pixels_due.push_back(typed ? want : px);
    samples_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // One register write beat; every write restarts the line.
  task automatic write_setting(input logic [aald_pkg::CfgIdxBits-1:0] idx,
                               input logic [aald_pkg::CfgBits-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      aald_pkg::RegSourceLength:  src_len_reg = data[aald_pkg::LenBits-1:0];
      aald_pkg::RegDestLength:    dst_len_reg = data[aald_pkg::LenBits-1:0];
      aald_pkg::RegInverseLength: inv_reg     = data[aald_pkg::InvBits-1:0];
      default: ;
    endcase
    start_new_line();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Waits until every pixel has come out and the block has gone quiet.
  task automatic settle();
    push       = 1'b0;
    burst_left = 0;
    while (pixels_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic plan_write(input logic [aald_pkg::CfgIdxBits-1:0] idx,
                            input logic [aald_pkg::CfgBits-1:0] data);
    plan_row_t r;
    r.kind     = ROW_WRITE;
    r.reg_idx  = idx;
    r.reg_data = data;
    r.sample   = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endtask

  task automatic plan_sample(input logic [aald_pkg::SampleBits-1:0] s, input bit typed,
                             input logic [aald_pkg::SampleBits-1:0] v, input logic done);
    plan_row_t r;
    r.kind           = ROW_SAMPLE;
    r.reg_idx        = '0;
    r.reg_data       = '0;
    r.sample         = s;
    r.typed          = typed;
    r.want.value     = v;
    r.want.line_done = done;
    plan.push_back(r);
  endtask

  function automatic logic [aald_pkg::SampleBits-1:0] gen_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return aald_pkg::SampleBits'($urandom_range(0, 15));
      default: return aald_pkg::SampleBits'($urandom);
    endcase
  endfunction

  function automatic int round_inverse(input int s_eff);
    return ((1 << 25) / s_eff + 1) / 2;
  endfunction

  // Receiver: switches at random between stall styles, and honors
  // one long hold-off on request.
  initial begin : drive_pop
    pop_style_e style;
    int         style_left;
    int         tick;
    pop        = 1'b0;
    style      = POP_ALWAYS;
    style_left = 0;
    tick       = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (style_left == 0) begin
        style      = pop_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end
      style_left--;
      tick++;
      case (style)
        POP_ALWAYS:      pop = 1'b1;
        POP_COIN:        pop = 1'($urandom_range(0, 1));
        POP_ONE_IN_FOUR: pop = (tick % 4 == 0);
        default:         pop = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Each pixel beat is checked against the oldest expected pixel.
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (pop === 1'b1 && empty === 1'b0) begin
      pixels_seen++;
      if (pixels_due.size() == 0) begin
        note_mismatch($sformatf("pixel %h/%b with nothing expected", value_o, line_done_o));
      end else begin
        want = pixels_due.pop_front();
        if (value_o !== want.value)
          note_mismatch($sformatf("value %h, expected %h", value_o, want.value));
        if (line_done_o !== want.line_done)
          note_mismatch($sformatf("line_done %b, expected %b", line_done_o, want.line_done));
      end
    end
  end

  // Stimulus: directed table, random settings and lines, then the start of a long clamped line.
  initial begin : stimulus
    int        src_w;
    int        dst_w;
    int        inv_w;
    int        s_eff;
    int        lines;
    int        tail;
    bit        dirty;
    bit        hold_used;
    int        guard;
    plan_row_t row;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    push        = 1'b0;
    sample_i    = '0;
    hold_req    = 1'b0;
    mismatches  = 0;
    samples_sent  = 0;
    pixels_seen   = 0;
    settings_used = 0;
    burst_left    = 0;
    dirty         = 1'b0;
    hold_used     = 1'b0;
    src_len_reg = aald_pkg::ResetSourceLength;
    dst_len_reg = aald_pkg::ResetDestLength;
    inv_reg     = aald_pkg::ResetInverse;
    start_new_line();

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // After reset one sample is one whole line and is passed through.
    plan_sample(16'h0000, 1, 16'h0000, 1'b1);
    plan_sample(16'hFFFF, 1, 16'hFFFF, 1'b1);
    plan_sample(16'h5A5A, 1, 16'h5A5A, 1'b1);
    // Largest reciprocal: the average saturates.
    plan_write(aald_pkg::RegInverseLength, 25'h1FFFFFF);
    plan_sample(16'hFFFF, 1, 16'hFFFF, 1'b1);
    plan_sample(16'h0001, 1, 16'h0001, 1'b1);
    plan_sample(16'h0002, 1, 16'h0003, 1'b1);
    // Zero reciprocal.
    plan_write(aald_pkg::RegInverseLength, '0);
    plan_sample(16'hFFFF, 1, 16'h0000, 1'b1);
    // Writes past the list change no setting.
    plan_write(RegNoneIdx, 25'h1555555);
    plan_sample(16'h04D2, 1, 16'h0000, 1'b1);
    plan_write(RegNoneIdx, 25'h0AAAAAA);
    // Zero lengths count as one.
    plan_write(aald_pkg::RegSourceLength, '0);
    plan_write(aald_pkg::RegDestLength, '0);
    plan_write(aald_pkg::RegInverseLength, 25'h1000000);
    plan_sample(16'd77, 1, 16'd77, 1'b1);
    // Destination longer than the source: clamped to it, one pixel per sample.
    plan_write(aald_pkg::RegSourceLength, 25'd3);
    plan_write(aald_pkg::RegDestLength, 25'd7);
    plan_write(aald_pkg::RegInverseLength, 25'd5592405);
    plan_sample(16'd100, 0, '0, 1'b0);
    plan_sample(16'h0000, 0, '0, 1'b0);
    plan_sample(16'hFFFF, 0, '0, 1'b0);
    // Both lengths clamp to the longest line; this line is cut short by the next write.
    plan_write(aald_pkg::RegSourceLength, 25'h1FFFFFF);
    plan_write(aald_pkg::RegDestLength, 25'h1FFFFFF);
    plan_write(aald_pkg::RegInverseLength, 25'd4096);
    plan_sample(16'hBEEF, 1, 16'hBEEF, 1'b0);
    plan_sample(16'h0001, 1, 16'h0001, 1'b0);
    // Five to two: samples straddle pixel boundaries.
    plan_write(aald_pkg::RegSourceLength, 25'd5);
    plan_write(aald_pkg::RegDestLength, 25'd2);
    plan_write(aald_pkg::RegInverseLength, 25'd3355443);
    plan_sample(16'd10, 0, '0, 1'b0);
    plan_sample(16'd20, 0, '0, 1'b0);
    plan_sample(16'd30, 0, '0, 1'b0);
    plan_sample(16'd40, 0, '0, 1'b0);
    plan_sample(16'd50, 0, '0, 1'b0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        if (dirty) begin
          settle();
          dirty = 1'b0;
          settings_used++;
        end
        write_setting(row.reg_idx, row.reg_data);
      end else begin
        push_sample(row.sample, row.typed, row.want);
        dirty = 1'b1;
      end
    end

    // Random settings, mostly whole lines, some lines broken off by a write.
    while (samples_sent < RandomItems) begin
      if (!hold_used && samples_sent >= 300) begin
        src_w = 64;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: src_w = $urandom_range(1, 24);
          6, 7:             src_w = $urandom_range(25, 200);
          8:                src_w = $urandom_range(0, 2);
          default:          src_w = $urandom_range(0, 8191);
        endcase
      end
      s_eff = (src_w == 0) ? 1 : ((src_w > 4096) ? 4096 : src_w);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: dst_w = $urandom_range(1, s_eff);
        7:                   dst_w = 0;
        8:                   dst_w = $urandom_range(s_eff, 8191);
        default:             dst_w = $urandom_range(0, 8191);
      endcase
      case ($urandom_range(0, 9))
        7:       inv_w = int'(aald_pkg::InvBits'($urandom));
        8:       inv_w = 25'h1FFFFFF;
        9:       inv_w = $urandom_range(0, 65535);
        default: inv_w = round_inverse(s_eff);
      endcase

      if (dirty) settle();
      dirty = 1'b0;
      if ($urandom_range(0, 3) == 0) write_setting(RegNoneIdx, aald_pkg::CfgBits'($urandom));
      write_setting(aald_pkg::RegSourceLength, {12'($urandom), aald_pkg::LenBits'(src_w)});
      write_setting(aald_pkg::RegDestLength, {12'($urandom), aald_pkg::LenBits'(dst_w)});
      write_setting(aald_pkg::RegInverseLength, aald_pkg::CfgBits'(inv_w));
      if ($urandom_range(0, 5) == 0) write_setting(RegNoneIdx, aald_pkg::CfgBits'($urandom));
      settings_used++;

      lines = (s_eff > 300) ? 0 : ((s_eff > 64) ? 1 : $urandom_range(1, 3));
      // Once, the receiver holds off while whole lines keep coming.
      if (!hold_used && src_w == 64) begin
        hold_used = 1'b1;
        hold_req  = 1'b1;
        lines     = 3;
      end
      for (int l = 0; l < lines; l++) begin
        for (int k = 0; k < s_eff; k++) push_sample(gen_sample(), 0, '0);
      end
      if (s_eff > 1 && (lines == 0 || $urandom_range(0, 3) == 0)) begin
        tail = $urandom_range(1, (s_eff - 1 < 40) ? s_eff - 1 : 40);
        for (int k = 0; k < tail; k++) push_sample(gen_sample(), 0, '0);
      end
      dirty = 1'b1;
    end

    // The start of a line at the longest length, the source length written out of range.
    settle();
    write_setting(aald_pkg::RegSourceLength, 25'h1FFFFFF);
    write_setting(aald_pkg::RegDestLength,
                  ($urandom_range(0, 1) == 0) ? 25'd8191
                                              : aald_pkg::CfgBits'($urandom_range(1, 4096)));
    write_setting(aald_pkg::RegInverseLength, aald_pkg::CfgBits'(round_inverse(4096)));
    settings_used++;
    for (int k = 0; k < FinalSamples; k++) push_sample(gen_sample(), 0, '0);

    // Drain, with a bound, then look for missing or extra pixels.
    push  = 1'b0;
    guard = 0;
    while (pixels_due.size() != 0 && guard < 50000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (pixels_due.size() != 0)
      note_mismatch($sformatf("%0d expected pixels never came out", pixels_due.size()));

    $display("Covered %0d samples under %0d settings, including clamped lengths,",
             samples_sent, settings_used);
    $display("saturation, broken lines and a full-input stall; %0d pixels, %0d mismatches.",
             pixels_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
